[rtl/core/lspc_pkg.sv]
// Shared types, constants and the arctangent table of the polar to Cartesian unit.
package lspc_pkg;

   localparam int RANGE_BITS    = 18;
   localparam int INDEX_BITS    = 12;
   localparam int MAX_SAMPLES   = 4096;
   localparam int CORDIC_STAGES = 18;
   localparam int TABLE_LEN     = 24;
   localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int SHIFT_BITS    = 5;

   localparam int ANGLE_BITS    = 32;
   localparam int CSR_BITS      = 32;
   localparam int CSR_IDX_BITS  = 2;

   localparam int GAIN_BITS     = 30;
   localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'd652032874;
   localparam int PROD_BITS     = RANGE_BITS + GAIN_BITS;
   localparam int X_SHIFT       = 14;
   localparam int FRAC_BITS     = 16;
   localparam int DATA_BITS     = RANGE_BITS + FRAC_BITS + 2;
   localparam int Z_BITS        = ANGLE_BITS + 2;
   localparam int POS_BITS      = RANGE_BITS + 1;

   localparam logic [RANGE_BITS-1:0] RANGE_MASK = {RANGE_BITS{1'b1}};

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_ANGLE_START = 2'd0,
      REG_ANGLE_STEP  = 2'd1,
      REG_RANGE_LOWER = 2'd2,
      REG_RANGE_UPPER = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] angle_start;
      logic [ANGLE_BITS-1:0] angle_step;
      logic [RANGE_BITS-1:0] range_lower;
      logic [RANGE_BITS-1:0] range_upper;
   } cfg_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] x;
      logic signed [DATA_BITS-1:0] y;
      logic signed [Z_BITS-1:0]    z;
      logic                        kept;
      logic [INDEX_BITS-1:0]       idx;
   } cord_type;

   function automatic logic signed [Z_BITS-1:0] atan_of(input logic [SHIFT_BITS-1:0] stage);
      logic signed [Z_BITS-1:0] value;
      unique case (stage)
         5'd0:  value = 34'sd536870912;
         5'd1:  value = 34'sd316933406;
         5'd2:  value = 34'sd167458907;
         5'd3:  value = 34'sd85004756;
         5'd4:  value = 34'sd42667331;
         5'd5:  value = 34'sd21354465;
         5'd6:  value = 34'sd10679838;
         5'd7:  value = 34'sd5340245;
         5'd8:  value = 34'sd2670163;
         5'd9:  value = 34'sd1335087;
         5'd10: value = 34'sd667544;
         5'd11: value = 34'sd333772;
         5'd12: value = 34'sd166886;
         5'd13: value = 34'sd83443;
         5'd14: value = 34'sd41722;
         5'd15: value = 34'sd20861;
         5'd16: value = 34'sd10430;
         5'd17: value = 34'sd5215;
         5'd18: value = 34'sd2608;
         5'd19: value = 34'sd1304;
         5'd20: value = 34'sd652;
         5'd21: value = 34'sd326;
         5'd22: value = 34'sd163;
         5'd23: value = 34'sd81;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

[rtl/core/lspc_req_if.sv]
// Request channel interface: one range sample and its index within the scan.
interface lspc_req_if;
   logic                              valid;
   logic                              ready;
   logic [lspc_pkg::RANGE_BITS-1:0]   range_mm;
   logic [lspc_pkg::INDEX_BITS-1:0]   sample_index;

   modport source (output valid, output range_mm, output sample_index, input ready);
   modport sink (input valid, input range_mm, input sample_index, output ready);
endinterface

[rtl/core/lspc_rsp_if.sv]
// Response channel interface: one Cartesian point with its kept flag and index.
interface lspc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [lspc_pkg::POS_BITS-1:0] pos_x;
   logic signed [lspc_pkg::POS_BITS-1:0] pos_y;
   logic                              point_kept;
   logic [lspc_pkg::INDEX_BITS-1:0]   index_echo;

   modport source (output valid, output pos_x, output pos_y, output point_kept,
                   output index_echo, input ready);
   modport sink (input valid, input pos_x, input pos_y, input point_kept,
                 input index_echo, output ready);
endinterface

[rtl/core/lspc_front.sv]
// Front end: gain and angle products, then quadrant folding into the CORDIC start vector.
module lspc_front (
   input  logic                  clock,
   input  logic                  reset,
   lspc_req_if.sink              req_bus,
   input  lspc_pkg::cfg_type     cfg,
   output logic                  out_valid,
   output lspc_pkg::cord_type    out_data,
   input  logic                  out_ready
);

   logic                                           s1_valid_ff, s1_valid_in;
   logic [lspc_pkg::PROD_BITS-1:0]                 s1_prod_ff;
   logic [lspc_pkg::ANGLE_BITS-1:0]                s1_turn_ff;
   logic                                           s1_kept_ff;
   logic [lspc_pkg::INDEX_BITS-1:0]                s1_idx_ff;
   logic                                           s1_ready;

   logic                                           s2_valid_ff, s2_valid_in;
   lspc_pkg::cord_type                             s2_data_ff, s2_data_in;
   logic                                           s2_ready;

   logic [lspc_pkg::PROD_BITS-1:0]                 prod_full;
   logic [lspc_pkg::INDEX_BITS+lspc_pkg::ANGLE_BITS-1:0] turn_full;
   logic                                           kept_now;

   logic [lspc_pkg::ANGLE_BITS-1:0]                angle;
   logic [lspc_pkg::PROD_BITS:0]                   rnd_sum;
   logic signed [lspc_pkg::DATA_BITS-1:0]          x_mag;
   logic                                           flip;
   logic [lspc_pkg::ANGLE_BITS-1:0]                angle_fix;

   assign s2_ready      = !s2_valid_ff || out_ready;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   assign prod_full = req_bus.range_mm * lspc_pkg::GAIN_Q30;
   assign turn_full = req_bus.sample_index * cfg.angle_step;
   assign kept_now  = (req_bus.range_mm > cfg.range_lower)
                   && (req_bus.range_mm < cfg.range_upper)
                   && (32'(req_bus.sample_index) < lspc_pkg::MAX_SAMPLES);

   assign s1_valid_in = s1_ready ? req_bus.valid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_bus.valid) begin
         s1_prod_ff <= prod_full;
         s1_turn_ff <= turn_full[lspc_pkg::ANGLE_BITS-1:0];
         s1_kept_ff <= kept_now;
         s1_idx_ff  <= req_bus.sample_index;
      end
   end

   always_comb begin
      angle     = cfg.angle_start + s1_turn_ff;
      rnd_sum   = (lspc_pkg::PROD_BITS+1)'(s1_prod_ff)
                + (lspc_pkg::PROD_BITS+1)'(2 ** (lspc_pkg::X_SHIFT - 1));
      x_mag     = lspc_pkg::DATA_BITS'(rnd_sum[lspc_pkg::PROD_BITS:lspc_pkg::X_SHIFT]);
      flip      = angle[lspc_pkg::ANGLE_BITS-1] ^ angle[lspc_pkg::ANGLE_BITS-2];
      angle_fix = {angle[lspc_pkg::ANGLE_BITS-1] ^ flip, angle[lspc_pkg::ANGLE_BITS-2:0]};
      s2_data_in.x    = flip ? -x_mag : x_mag;
      s2_data_in.y    = '0;
      s2_data_in.z    = lspc_pkg::Z_BITS'(signed'(angle_fix));
      s2_data_in.kept = s1_kept_ff;
      s2_data_in.idx  = s1_idx_ff;
   end

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

[rtl/core/lspc_cordic_cell.sv]
// One CORDIC rotation cell with its own pipeline register and handshake.
module lspc_cordic_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lspc_pkg::SHIFT_BITS-1:0]   shift,
   input  logic                              in_valid,
   input  lspc_pkg::cord_type                in_data,
   output logic                              in_ready,
   output logic                              out_valid,
   output lspc_pkg::cord_type                out_data,
   input  logic                              out_ready
);

   logic                                  valid_ff, valid_in;
   lspc_pkg::cord_type                    data_ff, data_in;
   logic signed [lspc_pkg::DATA_BITS-1:0] x_cur, y_cur, dx, dy;
   logic signed [lspc_pkg::Z_BITS-1:0]    z_cur, atan;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      x_cur = in_data.x;
      y_cur = in_data.y;
      z_cur = in_data.z;
      dx    = y_cur >>> shift;
      dy    = x_cur >>> shift;
      atan  = lspc_pkg::atan_of(shift);
      data_in = in_data;
      if (!z_cur[lspc_pkg::Z_BITS-1]) begin
         data_in.x = x_cur - dx;
         data_in.y = y_cur + dy;
         data_in.z = z_cur - atan;
      end else begin
         data_in.x = x_cur + dx;
         data_in.y = y_cur - dy;
         data_in.z = z_cur + atan;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/core/lspc_back.sv]
// Back end: rounds and saturates the rotated vector into the response register.
module lspc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  lspc_pkg::cord_type    in_data,
   output logic                  in_ready,
   lspc_rsp_if.source            rsp_bus
);

   localparam logic signed [lspc_pkg::DATA_BITS:0] ROUND_HALF =
      (lspc_pkg::DATA_BITS+1)'(2 ** (lspc_pkg::FRAC_BITS - 1));
   localparam logic signed [lspc_pkg::DATA_BITS:0] POS_LIMIT =
      (lspc_pkg::DATA_BITS+1)'(2 ** lspc_pkg::RANGE_BITS - 1);

   logic                                   valid_ff, valid_in;
   logic signed [lspc_pkg::POS_BITS-1:0]   pos_x_ff, pos_x_in;
   logic signed [lspc_pkg::POS_BITS-1:0]   pos_y_ff, pos_y_in;
   logic                                   kept_ff;
   logic [lspc_pkg::INDEX_BITS-1:0]        idx_ff;

   function automatic logic signed [lspc_pkg::POS_BITS-1:0] to_pos(
      input logic signed [lspc_pkg::DATA_BITS-1:0] v);
      logic signed [lspc_pkg::DATA_BITS:0] sum;
      logic signed [lspc_pkg::DATA_BITS:0] rnd;
      logic signed [lspc_pkg::DATA_BITS:0] sat;
      sum = (lspc_pkg::DATA_BITS+1)'(v) + ROUND_HALF;
      rnd = sum >>> lspc_pkg::FRAC_BITS;
      if (rnd > POS_LIMIT) begin
         sat = POS_LIMIT;
      end else if (rnd < -POS_LIMIT) begin
         sat = -POS_LIMIT;
      end else begin
         sat = rnd;
      end
      return sat[lspc_pkg::POS_BITS-1:0];
   endfunction

   assign in_ready = !valid_ff || rsp_bus.ready;
   assign pos_x_in = to_pos(in_data.x);
   assign pos_y_in = to_pos(in_data.y);
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         kept_ff  <= in_data.kept;
         idx_ff   <= in_data.idx;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.pos_x      = pos_x_ff;
   assign rsp_bus.pos_y      = pos_y_ff;
   assign rsp_bus.point_kept = kept_ff;
   assign rsp_bus.index_echo = idx_ff;

endmodule

[rtl/core/laser_scan_polar_to_cartesian_unit.sv]
// Top level of the lidar polar to Cartesian unit: registers, front end, cell row, back end.
// A request passes through two front-end stages, one stage per CORDIC cell (18 cells)
// and the response register on its way to its response.
// Throughput is one request per cycle while responses are taken; every stage has its own valid and register, so
// requests keep entering while a response waits, until all stages hold a request.
// Synchronous reset empties all stages and loads the register reset values.
module laser_scan_polar_to_cartesian_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   lspc_req_if.sink                             req_bus,
   lspc_rsp_if.source                           rsp_bus,
   input  logic                                 csr_we,
   input  logic [lspc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [lspc_pkg::CSR_BITS-1:0]        csr_wdata
);

   lspc_pkg::cfg_type   cfg_ff, cfg_in;

   logic                chain_valid [0:lspc_pkg::NUM_CELLS];
   logic                chain_ready [0:lspc_pkg::NUM_CELLS];
   lspc_pkg::cord_type  chain_data  [0:lspc_pkg::NUM_CELLS];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (lspc_pkg::csr_index_type'(csr_index))
            lspc_pkg::REG_ANGLE_START: cfg_in.angle_start = csr_wdata;
            lspc_pkg::REG_ANGLE_STEP:  cfg_in.angle_step  = csr_wdata;
            lspc_pkg::REG_RANGE_LOWER:
               cfg_in.range_lower = csr_wdata[lspc_pkg::RANGE_BITS-1:0];
            lspc_pkg::REG_RANGE_UPPER:
               cfg_in.range_upper = csr_wdata[lspc_pkg::RANGE_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_start <= '0;
         cfg_ff.angle_step  <= '0;
         cfg_ff.range_lower <= '0;
         cfg_ff.range_upper <= lspc_pkg::RANGE_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lspc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg_ff),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0]),
      .out_ready (chain_ready[0])
   );

   for (genvar g = 0; g < lspc_pkg::NUM_CELLS; g++) begin : g_cell
      lspc_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift     (lspc_pkg::SHIFT_BITS'(g)),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .in_ready  (chain_ready[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1]),
         .out_ready (chain_ready[g+1])
      );
   end

   lspc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain_valid[lspc_pkg::NUM_CELLS]),
      .in_data  (chain_data[lspc_pkg::NUM_CELLS]),
      .in_ready (chain_ready[lspc_pkg::NUM_CELLS]),
      .rsp_bus  (rsp_bus)
   );

endmodule

[bench/tb_laser_scan_polar_to_cartesian_unit.sv]
// Self-checking testbench for the lidar polar to Cartesian unit, with a bit-exact CORDIC predictor.
module tb_laser_scan_polar_to_cartesian_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [lspc_pkg::RANGE_BITS-1:0] range_mm;
      logic [lspc_pkg::INDEX_BITS-1:0] sample_index;
   } sample_type;

   typedef struct packed {
      logic [lspc_pkg::POS_BITS-1:0]   pos_x;
      logic [lspc_pkg::POS_BITS-1:0]   pos_y;
      logic                            point_kept;
      logic [lspc_pkg::INDEX_BITS-1:0] index_echo;
   } point_type;

   localparam longint SCALE_GAIN = 64'd652032874;

   longint beam_atan [24] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   lspc_pkg::csr_index_type csr_index;
   logic [lspc_pkg::CSR_BITS-1:0] csr_wdata;

   lspc_req_if req_bus ();
   lspc_rsp_if rsp_bus ();

   laser_scan_polar_to_cartesian_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [lspc_pkg::ANGLE_BITS-1:0] cfg_start;
   logic [lspc_pkg::ANGLE_BITS-1:0] cfg_step;
   logic [lspc_pkg::RANGE_BITS-1:0] cfg_lower;
   logic [lspc_pkg::RANGE_BITS-1:0] cfg_upper;

   sample_type pending_samples [$];
   point_type  expected_points [$];
   sample_type next_sample;
   point_type  want;

   logic req_done = 1'b0;
   logic idling_on = 1'b1;
   int   req_gap = 0;
   int   rsp_gap = 0;
   int   queued_count = 0;
   int   checked_count = 0;
   int   kept_count = 0;
   int   setting_count = 0;
   int   error_count = 0;

   always #2 clock = ~clock;

   function automatic logic [lspc_pkg::POS_BITS-1:0] round_to_mm(longint value);
      longint rounded;
      longint limit;
      rounded = (value + 64'sd32768) >>> 16;
      limit = (64'sd1 <<< lspc_pkg::RANGE_BITS) - 1;
      if (rounded > limit) begin
         rounded = limit;
      end
      if (rounded < -limit) begin
         rounded = -limit;
      end
      return rounded[lspc_pkg::POS_BITS-1:0];
   endfunction

   function automatic point_type predict_point(logic [lspc_pkg::RANGE_BITS-1:0] range_mm,
                                               logic [lspc_pkg::INDEX_BITS-1:0] idx);
      logic [lspc_pkg::ANGLE_BITS-1:0] angle;
      longint    range_wide;
      longint    x;
      longint    y;
      longint    z;
      longint    dx;
      longint    dy;
      point_type p;
      range_wide = longint'(range_mm);
      angle = cfg_start + cfg_step * idx;
      x = (range_wide * SCALE_GAIN + 64'sd8192) >>> 14;
      y = 0;
      // Beams in the left half plane are rotated by a half turn first.
      if (angle[31:30] == 2'b01 || angle[31:30] == 2'b10) begin
         x = -x;
         angle = angle + 32'h8000_0000;
      end
      z = longint'($signed(angle));
      for (int i = 0; i < lspc_pkg::CORDIC_STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - beam_atan[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + beam_atan[i];
         end
      end
      p.pos_x = round_to_mm(x);
      p.pos_y = round_to_mm(y);
      p.point_kept = (range_mm > cfg_lower) && (range_mm < cfg_upper)
                  && (idx < lspc_pkg::MAX_SAMPLES);
      p.index_echo = idx;
      return p;
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic wait_idle();
      wait (checked_count == queued_count);
      @(negedge clock);
   endtask

   task automatic write_reg(lspc_pkg::csr_index_type which,
                            logic [lspc_pkg::CSR_BITS-1:0] value);
      logic [lspc_pkg::CSR_BITS-1:0] bus_value;
      bus_value = value;
      case (which)
         lspc_pkg::REG_ANGLE_START: cfg_start = value;
         lspc_pkg::REG_ANGLE_STEP:  cfg_step = value;
         lspc_pkg::REG_RANGE_LOWER: begin
            cfg_lower = value[lspc_pkg::RANGE_BITS-1:0];
            bus_value[lspc_pkg::CSR_BITS-1:lspc_pkg::RANGE_BITS] =
               (lspc_pkg::CSR_BITS-lspc_pkg::RANGE_BITS)'($urandom);
         end
         lspc_pkg::REG_RANGE_UPPER: begin
            cfg_upper = value[lspc_pkg::RANGE_BITS-1:0];
            bus_value[lspc_pkg::CSR_BITS-1:lspc_pkg::RANGE_BITS] =
               (lspc_pkg::CSR_BITS-lspc_pkg::RANGE_BITS)'($urandom);
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= which;
      csr_wdata <= bus_value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(logic [31:0] start, logic [31:0] step,
                                 logic [lspc_pkg::RANGE_BITS-1:0] lower,
                                 logic [lspc_pkg::RANGE_BITS-1:0] upper);
      wait_idle();
      write_reg(lspc_pkg::REG_ANGLE_START, start);
      write_reg(lspc_pkg::REG_ANGLE_STEP, step);
      write_reg(lspc_pkg::REG_RANGE_LOWER, 32'(lower));
      write_reg(lspc_pkg::REG_RANGE_UPPER, 32'(upper));
      setting_count++;
   endtask

   task automatic queue_sample(logic [lspc_pkg::RANGE_BITS-1:0] range_mm,
                               logic [lspc_pkg::INDEX_BITS-1:0] idx);
      sample_type s;
      s.range_mm = range_mm;
      s.sample_index = idx;
      pending_samples = {pending_samples, s};
      queued_count++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_done = 1'b0;
      end else if (!req_bus.valid || req_done) begin
         req_done = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            req_gap = int'($urandom_range(0, 13));
            req_bus.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            next_sample = pending_samples.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.range_mm <= next_sample.range_mm;
            req_bus.sample_index <= next_sample.sample_index;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         rsp_gap = int'($urandom_range(0, 13));
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            expected_points = {expected_points,
                               predict_point(req_bus.range_mm, req_bus.sample_index)};
            req_done = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("response for index %0d with no request pending",
                                         rsp_bus.index_echo));
            end else begin
               want = expected_points.pop_front();
               if (rsp_bus.pos_x !== want.pos_x) begin
                  report_mismatch($sformatf("index %0d pos_x expected %0h, got %0h",
                                            want.index_echo, want.pos_x, rsp_bus.pos_x));
               end
               if (rsp_bus.pos_y !== want.pos_y) begin
                  report_mismatch($sformatf("index %0d pos_y expected %0h, got %0h",
                                            want.index_echo, want.pos_y, rsp_bus.pos_y));
               end
               if (rsp_bus.point_kept !== want.point_kept) begin
                  report_mismatch($sformatf("index %0d point_kept expected %0b, got %0b",
                                            want.index_echo, want.point_kept,
                                            rsp_bus.point_kept));
               end
               if (rsp_bus.index_echo !== want.index_echo) begin
                  report_mismatch($sformatf("index_echo expected %0d, got %0d",
                                            want.index_echo, rsp_bus.index_echo));
               end
               if (want.point_kept) begin
                  kept_count++;
               end
               checked_count++;
            end
         end
      end
   end

   initial begin
      int scan_pos;
      logic [lspc_pkg::RANGE_BITS-1:0] rng;
      logic [lspc_pkg::INDEX_BITS-1:0] idx;
      logic [31:0] step;
      logic [lspc_pkg::RANGE_BITS-1:0] lo;
      logic [lspc_pkg::RANGE_BITS-1:0] hi;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = lspc_pkg::REG_ANGLE_START;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.range_mm = '0;
      req_bus.sample_index = '0;
      rsp_bus.ready = 1'b0;
      cfg_start = '0;
      cfg_step = '0;
      cfg_lower = '0;
      cfg_upper = lspc_pkg::RANGE_MASK;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Register reset values, including the no-return range that is dropped at reset.
      queue_sample(18'd0, 12'd0);
      queue_sample(18'd1, 12'd0);
      queue_sample(lspc_pkg::RANGE_MASK, 12'd4095);
      queue_sample(lspc_pkg::RANGE_MASK - 18'd1, 12'd1);
      queue_sample(18'd131072, 12'd2048);

      // Quarter-turn steps and both strict window edges.
      apply_settings(32'h0000_0000, 32'h4000_0000, 18'd1000, 18'd2000);
      for (int i = 0; i < 4; i++) begin
         queue_sample(18'd1500, lspc_pkg::INDEX_BITS'(i));
      end
      queue_sample(18'd1000, 12'd4);
      queue_sample(18'd1001, 12'd5);
      queue_sample(18'd1999, 12'd6);
      queue_sample(18'd2000, 12'd4095);

      // Angle register extremes and an inverted, empty window.
      apply_settings(32'h7FFF_FFFF, 32'h8000_0000, lspc_pkg::RANGE_MASK, 18'd0);
      queue_sample(lspc_pkg::RANGE_MASK, 12'd0);
      queue_sample(lspc_pkg::RANGE_MASK, 12'd1);
      queue_sample(lspc_pkg::RANGE_MASK, 12'd4095);
      queue_sample(18'd0, 12'd2);
      queue_sample(18'd1, 12'd3);

      // Beams on either side of the half-plane boundaries.
      apply_settings(32'h3FFF_FFFF, 32'h0000_0001, 18'd0, lspc_pkg::RANGE_MASK);
      queue_sample(lspc_pkg::RANGE_MASK - 18'd1, 12'd0);
      queue_sample(lspc_pkg::RANGE_MASK - 18'd1, 12'd1);
      apply_settings(32'hBFFF_FFFF, 32'h0000_0001, 18'd0, lspc_pkg::RANGE_MASK);
      queue_sample(lspc_pkg::RANGE_MASK - 18'd1, 12'd0);
      queue_sample(lspc_pkg::RANGE_MASK - 18'd1, 12'd1);

      for (int seg = 0; seg < 6; seg++) begin
         case ($urandom_range(0, 3))
            0: step = $urandom;
            1: step = $urandom_range(1, 32'h0010_0000);
            2: step = 32'd0 - $urandom_range(1, 32'h0010_0000);
            default: step = 32'h0010_0000;
         endcase
         if (seg == 5) begin
            lo = '0;
            hi = lspc_pkg::RANGE_MASK;
         end else begin
            lo = lspc_pkg::RANGE_BITS'($urandom_range(0, 3000));
            hi = lspc_pkg::RANGE_BITS'($urandom_range(20000, 262143));
         end
         apply_settings($urandom, step, lo, hi);
         idling_on = (seg < 4) && (seg != 2);
         scan_pos = int'($urandom_range(0, 4095));
         for (int n = 0; n < 75; n++) begin
            case ($urandom_range(0, 9))
               7: begin
                  rng = lspc_pkg::RANGE_MASK;
                  idx = lspc_pkg::INDEX_BITS'(scan_pos);
                  scan_pos++;
               end
               8: begin
                  case ($urandom_range(0, 3))
                     0: rng = cfg_lower;
                     1: rng = cfg_lower + 18'd1;
                     2: rng = cfg_upper - 18'd1;
                     default: rng = cfg_upper;
                  endcase
                  idx = lspc_pkg::INDEX_BITS'(scan_pos);
                  scan_pos++;
               end
               9: begin
                  rng = lspc_pkg::RANGE_BITS'($urandom);
                  idx = lspc_pkg::INDEX_BITS'($urandom);
               end
               default: begin
                  if ($urandom_range(0, 2) == 0) begin
                     rng = lspc_pkg::RANGE_BITS'($urandom);
                  end else begin
                     rng = lspc_pkg::RANGE_BITS'($urandom_range(0, 40000));
                  end
                  idx = lspc_pkg::INDEX_BITS'(scan_pos);
                  scan_pos++;
               end
            endcase
            queue_sample(rng, idx);
         end
      end

      wait_idle();
      repeat (25) @(negedge clock);
      if (expected_points.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_points.size()));
      end
      $display("Checked %0d points (%0d kept) under %0d register settings,",
               checked_count, kept_count, setting_count);
      $display("covering all quadrants, window edges, no-return ranges and handshake stalls.");
      if (error_count == 0) begin
         $display("[laser_scan_polar_to_cartesian_unit] OK");
      end else begin
         $display("[laser_scan_polar_to_cartesian_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[laser_scan_polar_to_cartesian_unit] ERROR");
      $finish;
   end

endmodule

[filelist.f]
rtl/core/lspc_pkg.sv
rtl/core/lspc_req_if.sv
rtl/core/lspc_rsp_if.sv
rtl/core/lspc_front.sv
rtl/core/lspc_cordic_cell.sv
rtl/core/lspc_back.sv
rtl/core/laser_scan_polar_to_cartesian_unit.sv
bench/tb_laser_scan_polar_to_cartesian_unit.sv
